>>> sv/three_class_priority_packet_queue_core_defines.svh
// Assertion macros for the three-class priority packet queue.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef THREE_CLASS_PRIORITY_PACKET_QUEUE_CORE_DEFINES_SVH
`define THREE_CLASS_PRIORITY_PACKET_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TCPQ_CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpq same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TCPQ_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpq next-cycle check failed");

`endif

>>> sv/tcpq_pkg.sv
// Package for the three-class priority packet queue: codes, request and
// result types, and the byte-keeping helper. No dependencies.
`default_nettype none

package tcpq_pkg;

    // Default ring depths
    localparam int URGENT_DEPTH_DEF = 4;
    localparam int VOICE_DEPTH_DEF  = 8;
    localparam int DATA_DEPTH_DEF   = 8;

    // Longest packet in bytes
    localparam int MAX_BYTES = 8;

    // Field widths
    localparam int LEN_W     = 4;
    localparam int URG_CNT_W = 3;
    localparam int VOI_CNT_W = 4;
    localparam int DAT_CNT_W = 4;
    localparam int CFG_IDX_W = 2;

    // Request kinds
    localparam logic [1:0] KIND_ENQUEUE = 2'd0;
    localparam logic [1:0] KIND_DEQUEUE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_FLUSH   = 2'd3;

    // Traffic classes
    localparam logic [1:0] CLASS_URGENT  = 2'd0;
    localparam logic [1:0] CLASS_VOICE   = 2'd1;
    localparam logic [1:0] CLASS_DATA    = 2'd2;
    localparam logic [1:0] CLASS_INVALID = 2'd3;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_FULL      = 3'd1;
    localparam logic [2:0] STAT_OVERSIZE  = 3'd2;
    localparam logic [2:0] STAT_BAD_CLASS = 3'd3;
    localparam logic [2:0] STAT_EMPTY     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AGING_LIMIT        = 2'd1;

    // Reset values of the configuration registers
    localparam logic [31:0] SUPPRESS_THRESHOLD_RST = 32'd500;
    localparam logic [31:0] AGING_LIMIT_RST        = 32'd2000;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       priority_req;
        logic [63:0]      payload;
        logic [LEN_W-1:0] length;
        logic [31:0]      time_ms;
        logic [31:0]      noise_floor;
        logic [LEN_W-1:0] out_capacity;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [63:0]          out_payload;
        logic [LEN_W-1:0]     out_length;
        logic [1:0]           out_class;
        logic [URG_CNT_W-1:0] urgent_count;
        logic [VOI_CNT_W-1:0] voice_count;
        logic [DAT_CNT_W-1:0] data_count;
        logic                 data_withheld;
    } rsp_t;

    // Keep the low len bytes of a payload, zero the rest
    function automatic logic [63:0] keep_bytes(input logic [63:0] pay,
                                               input logic [LEN_W-1:0] len);
        logic [63:0] res;
        res = '0;
        for (int i = 0; i < 8; i++) begin
            if (LEN_W'(i) < len) begin
                res[8*i +: 8] = pay[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/three_class_priority_packet_queue_core.sv
// Three-class strict-priority packet queue with data aging and suppression.
// Depends on tcpq_pkg and three_class_priority_packet_queue_core_defines.svh.
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+---------------------------
//  request | req_valid, req_ready, req        | in        | enqueue/dequeue/tick/flush
//  result  | rsp_valid, rsp_ready, rsp        | out       | status, packet, counts
//  config  | cfg_valid, cfg_ready, cfg_index, | in        | threshold, aging limit
//          | cfg_data                         |           |
//
// One request per cycle while the result side does not stall: the request is worked
// out in one pass over the ring heads and written into the result register at the
// edge that takes it. The result register frees in the cycle it is taken, so
// req_ready follows rsp_ready while a result is held. Reset clears ring pointers,
// fill counts, the withhold flag and rsp_valid, and loads the config registers with
// their reset values; ring contents are not cleared. Config writes are taken in every cycle.
`default_nettype none
`include "three_class_priority_packet_queue_core_defines.svh"

module three_class_priority_packet_queue_core #(
    parameter int URGENT_DEPTH = tcpq_pkg::URGENT_DEPTH_DEF,
    parameter int VOICE_DEPTH  = tcpq_pkg::VOICE_DEPTH_DEF,
    parameter int DATA_DEPTH   = tcpq_pkg::DATA_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire tcpq_pkg::req_t                 req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output tcpq_pkg::rsp_t                      rsp,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tcpq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                    cfg_data
);

    localparam int UP_W = (URGENT_DEPTH > 1) ? $clog2(URGENT_DEPTH) : 1;
    localparam int VP_W = (VOICE_DEPTH > 1) ? $clog2(VOICE_DEPTH) : 1;
    localparam int DP_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int UF_W = $clog2(URGENT_DEPTH + 1);
    localparam int VF_W = $clog2(VOICE_DEPTH + 1);
    localparam int DF_W = $clog2(DATA_DEPTH + 1);
    localparam int LW   = tcpq_pkg::LEN_W;
    localparam int UCW  = tcpq_pkg::URG_CNT_W;
    localparam int VCW  = tcpq_pkg::VOI_CNT_W;
    localparam int DCW  = tcpq_pkg::DAT_CNT_W;

    localparam logic [UP_W-1:0] U_LAST = UP_W'(URGENT_DEPTH - 1);
    localparam logic [VP_W-1:0] V_LAST = VP_W'(VOICE_DEPTH - 1);
    localparam logic [DP_W-1:0] D_LAST = DP_W'(DATA_DEPTH - 1);
    localparam logic [UF_W-1:0] U_FULL = UF_W'(URGENT_DEPTH);
    localparam logic [VF_W-1:0] V_FULL = VF_W'(VOICE_DEPTH);
    localparam logic [DF_W-1:0] D_FULL = DF_W'(DATA_DEPTH);
    localparam logic [LW-1:0]   LEN_MAX = LW'(tcpq_pkg::MAX_BYTES);

    // Ring stores
    logic [63:0]   urgent_bytes [URGENT_DEPTH];
    logic [LW-1:0] urgent_sizes [URGENT_DEPTH];
    logic [63:0]   voice_bytes  [VOICE_DEPTH];
    logic [LW-1:0] voice_sizes  [VOICE_DEPTH];
    logic [63:0]   data_bytes   [DATA_DEPTH];
    logic [LW-1:0] data_sizes   [DATA_DEPTH];
    logic [31:0]   data_stamps  [DATA_DEPTH];

    // Ring pointers, fills and flags
    logic [UP_W-1:0] urgent_head_reg, urgent_head_next, urgent_tail_reg, urgent_tail_next;
    logic [UF_W-1:0] urgent_fill_reg, urgent_fill_next;
    logic [VP_W-1:0] voice_head_reg, voice_head_next, voice_tail_reg, voice_tail_next;
    logic [VF_W-1:0] voice_fill_reg, voice_fill_next;
    logic [DP_W-1:0] data_head_reg, data_head_next, data_tail_reg, data_tail_next;
    logic [DF_W-1:0] data_fill_reg, data_fill_next;
    logic            withhold_reg, withhold_next;
    logic [31:0]     threshold_reg, aging_limit_reg;

    logic           rsp_valid_reg, rsp_valid_next;
    tcpq_pkg::rsp_t rsp_reg, rsp_next;

    logic          req_fire;
    logic          u_wr, v_wr, d_wr;
    logic [63:0]   v_wr_bytes;
    logic [LW-1:0] v_wr_size;
    logic [63:0]   kept_bytes;
    logic [LW-1:0] u_head_size, v_head_size, d_head_size;
    logic [31:0]   d_age;
    logic          u_can, v_can, d_can;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Look at the ring heads
    assign u_head_size = urgent_sizes[urgent_head_reg];
    assign v_head_size = voice_sizes[voice_head_reg];
    assign d_head_size = data_sizes[data_head_reg];
    assign d_age       = req.time_ms - data_stamps[data_head_reg];
    assign kept_bytes  = tcpq_pkg::keep_bytes(req.payload, req.length);

    assign u_can = (urgent_fill_reg != '0) && (u_head_size <= req.out_capacity);
    assign v_can = (voice_fill_reg != '0) && (v_head_size <= req.out_capacity);
    assign d_can = !withhold_reg && (data_fill_reg != '0)
                   && (d_head_size <= req.out_capacity);

    // Work out one request
    always_comb
    begin
        urgent_head_next = urgent_head_reg;
        urgent_tail_next = urgent_tail_reg;
        urgent_fill_next = urgent_fill_reg;
        voice_head_next  = voice_head_reg;
        voice_tail_next  = voice_tail_reg;
        voice_fill_next  = voice_fill_reg;
        data_head_next   = data_head_reg;
        data_tail_next   = data_tail_reg;
        data_fill_next   = data_fill_reg;
        withhold_next    = withhold_reg;
        u_wr             = 1'b0;
        v_wr             = 1'b0;
        d_wr             = 1'b0;
        v_wr_bytes       = kept_bytes;
        v_wr_size        = req.length;
        rsp_next         = '0;
        rsp_next.status  = tcpq_pkg::STAT_OK;

        if (req_fire)
        begin
            unique case (req.kind)
                tcpq_pkg::KIND_ENQUEUE:
                begin
                    priority if (req.length == '0 || req.length > LEN_MAX)
                    begin
                        rsp_next.status = tcpq_pkg::STAT_OVERSIZE;
                    end
                    else if (req.priority_req == tcpq_pkg::CLASS_INVALID)
                    begin
                        rsp_next.status = tcpq_pkg::STAT_BAD_CLASS;
                    end
                    else if (req.priority_req == tcpq_pkg::CLASS_URGENT)
                    begin
                        if (urgent_fill_reg == U_FULL)
                        begin
                            rsp_next.status = tcpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            u_wr             = 1'b1;
                            urgent_tail_next = (urgent_tail_reg == U_LAST) ? '0
                                               : urgent_tail_reg + 1'b1;
                            urgent_fill_next = urgent_fill_reg + 1'b1;
                        end
                    end
                    else if (req.priority_req == tcpq_pkg::CLASS_VOICE)
                    begin
                        if (voice_fill_reg == V_FULL)
                        begin
                            rsp_next.status = tcpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            v_wr            = 1'b1;
                            voice_tail_next = (voice_tail_reg == V_LAST) ? '0
                                              : voice_tail_reg + 1'b1;
                            voice_fill_next = voice_fill_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (data_fill_reg == D_FULL)
                        begin
                            rsp_next.status = tcpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            d_wr           = 1'b1;
                            data_tail_next = (data_tail_reg == D_LAST) ? '0
                                             : data_tail_reg + 1'b1;
                            data_fill_next = data_fill_reg + 1'b1;
                        end
                    end
                end

                tcpq_pkg::KIND_DEQUEUE:
                begin
                    priority if (u_can)
                    begin
                        rsp_next.out_payload = urgent_bytes[urgent_head_reg];
                        rsp_next.out_length  = u_head_size;
                        rsp_next.out_class   = tcpq_pkg::CLASS_URGENT;
                        urgent_head_next = (urgent_head_reg == U_LAST) ? '0
                                           : urgent_head_reg + 1'b1;
                        urgent_fill_next = urgent_fill_reg - 1'b1;
                    end
                    else if (v_can)
                    begin
                        rsp_next.out_payload = voice_bytes[voice_head_reg];
                        rsp_next.out_length  = v_head_size;
                        rsp_next.out_class   = tcpq_pkg::CLASS_VOICE;
                        voice_head_next = (voice_head_reg == V_LAST) ? '0
                                          : voice_head_reg + 1'b1;
                        voice_fill_next = voice_fill_reg - 1'b1;
                    end
                    else if (d_can)
                    begin
                        rsp_next.out_payload = data_bytes[data_head_reg];
                        rsp_next.out_length  = d_head_size;
                        rsp_next.out_class   = tcpq_pkg::CLASS_DATA;
                        data_head_next = (data_head_reg == D_LAST) ? '0
                                         : data_head_reg + 1'b1;
                        data_fill_next = data_fill_reg - 1'b1;
                    end
                    else
                    begin
                        rsp_next.status = tcpq_pkg::STAT_EMPTY;
                    end
                end

                tcpq_pkg::KIND_TICK:
                begin
                    withhold_next = req.noise_floor > threshold_reg;
                    // Promote an aged data head to the voice tail
                    if (data_fill_reg != '0 && d_age >= aging_limit_reg
                        && voice_fill_reg != V_FULL)
                    begin
                        v_wr            = 1'b1;
                        v_wr_bytes      = data_bytes[data_head_reg];
                        v_wr_size       = d_head_size;
                        voice_tail_next = (voice_tail_reg == V_LAST) ? '0
                                          : voice_tail_reg + 1'b1;
                        voice_fill_next = voice_fill_reg + 1'b1;
                        data_head_next  = (data_head_reg == D_LAST) ? '0
                                          : data_head_reg + 1'b1;
                        data_fill_next  = data_fill_reg - 1'b1;
                    end
                end

                tcpq_pkg::KIND_FLUSH:
                begin
                    urgent_head_next = '0;
                    urgent_tail_next = '0;
                    urgent_fill_next = '0;
                    voice_head_next  = '0;
                    voice_tail_next  = '0;
                    voice_fill_next  = '0;
                    data_head_next   = '0;
                    data_tail_next   = '0;
                    data_fill_next   = '0;
                end

                default:
                begin
                    rsp_next.status = tcpq_pkg::STAT_OK;
                end
            endcase
        end

        rsp_next.urgent_count  = UCW'(urgent_fill_next);
        rsp_next.voice_count   = VCW'(voice_fill_next);
        rsp_next.data_count    = DCW'(data_fill_next);
        rsp_next.data_withheld = withhold_next;
    end

    // Hold a result until taken
    assign rsp_valid_next = req_fire ? 1'b1 : (rsp_valid_reg && !rsp_ready);

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            urgent_head_reg <= '0;
            urgent_tail_reg <= '0;
            urgent_fill_reg <= '0;
            voice_head_reg  <= '0;
            voice_tail_reg  <= '0;
            voice_fill_reg  <= '0;
            data_head_reg   <= '0;
            data_tail_reg   <= '0;
            data_fill_reg   <= '0;
            withhold_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            threshold_reg   <= tcpq_pkg::SUPPRESS_THRESHOLD_RST;
            aging_limit_reg <= tcpq_pkg::AGING_LIMIT_RST;
        end
        else
        begin
            urgent_head_reg <= urgent_head_next;
            urgent_tail_reg <= urgent_tail_next;
            urgent_fill_reg <= urgent_fill_next;
            voice_head_reg  <= voice_head_next;
            voice_tail_reg  <= voice_tail_next;
            voice_fill_reg  <= voice_fill_next;
            data_head_reg   <= data_head_next;
            data_tail_reg   <= data_tail_next;
            data_fill_reg   <= data_fill_next;
            withhold_reg    <= withhold_next;
            rsp_valid_reg   <= rsp_valid_next;
            // Write a config register; unknown indexes drop
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == tcpq_pkg::REG_SUPPRESS_THRESHOLD)
                begin
                    threshold_reg <= cfg_data;
                end
                else if (cfg_index == tcpq_pkg::REG_AGING_LIMIT)
                begin
                    aging_limit_reg <= cfg_data;
                end
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Write the ring stores at their tails
    always_ff @(posedge clk)
    begin
        if (u_wr)
        begin
            urgent_bytes[urgent_tail_reg] <= kept_bytes;
            urgent_sizes[urgent_tail_reg] <= req.length;
        end
        if (v_wr)
        begin
            voice_bytes[voice_tail_reg] <= v_wr_bytes;
            voice_sizes[voice_tail_reg] <= v_wr_size;
        end
        if (d_wr)
        begin
            data_bytes[data_tail_reg]  <= kept_bytes;
            data_sizes[data_tail_reg]  <= req.length;
            data_stamps[data_tail_reg] <= req.time_ms;
        end
    end

    // Checks
    logic fills_in_range, flush_fire, rings_empty, rsp_err;

    assign fills_in_range = (urgent_fill_reg <= U_FULL) && (voice_fill_reg <= V_FULL)
                            && (data_fill_reg <= D_FULL);
    assign flush_fire     = req_fire && (req.kind == tcpq_pkg::KIND_FLUSH);
    assign rings_empty    = (urgent_fill_reg == '0) && (voice_fill_reg == '0)
                            && (data_fill_reg == '0);
    assign rsp_err        = rsp_valid_reg && (rsp_reg.status != tcpq_pkg::STAT_OK);

    `TCPQ_CHK_SAME(a_fill_bound, 1'b1, fills_in_range)
    `TCPQ_CHK_NEXT(a_req_gives_rsp, req_fire, rsp_valid_reg)
    `TCPQ_CHK_NEXT(a_flush_empties, flush_fire, rings_empty)
    `TCPQ_CHK_SAME(a_no_packet_on_error, rsp_err, rsp_reg.out_length == '0)

endmodule

`default_nettype wire

>>> tb/three_class_priority_packet_queue_core_tb.sv
// Self-checking testbench for the three-class priority packet queue core.
// A scoreboard predicts each result from the accepted requests; depends only
// on tcpq_pkg and the core itself.
module three_class_priority_packet_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 270;
    localparam int NUM_PHASES     = 6;
    localparam int LW             = tcpq_pkg::LEN_W;
    localparam int UDEP           = tcpq_pkg::URGENT_DEPTH_DEF;
    localparam int VDEP           = tcpq_pkg::VOICE_DEPTH_DEF;
    localparam int DDEP           = tcpq_pkg::DATA_DEPTH_DEF;

    // Predicts the queue's answer to each request and checks results in order
    class packet_queue_scoreboard;
        logic [63:0]      urg_pkt [UDEP];
        logic [LW-1:0]    urg_len [UDEP];
        logic [63:0]      voi_pkt [VDEP];
        logic [LW-1:0]    voi_len [VDEP];
        logic [63:0]      dat_pkt [DDEP];
        logic [LW-1:0]    dat_len [DDEP];
        logic [31:0]      dat_stamp [DDEP];
        int               urg_rd, urg_wr, urg_cnt;
        int               voi_rd, voi_wr, voi_cnt;
        int               dat_rd, dat_wr, dat_cnt;
        logic [31:0]      threshold;
        logic [31:0]      aging_limit;
        bit               withheld;
        tcpq_pkg::rsp_t   expected_results[$];
        int               errors;
        int               results_checked;
        int               n_enq, n_deq, n_tick, n_flush, n_served, n_promoted;

        function new();
            threshold   = tcpq_pkg::SUPPRESS_THRESHOLD_RST;
            aging_limit = tcpq_pkg::AGING_LIMIT_RST;
            withheld    = 1'b0;
            urg_rd = 0; urg_wr = 0; urg_cnt = 0;
            voi_rd = 0; voi_wr = 0; voi_cnt = 0;
            dat_rd = 0; dat_wr = 0; dat_cnt = 0;
            errors = 0;
            results_checked = 0;
            n_enq = 0; n_deq = 0; n_tick = 0; n_flush = 0; n_served = 0; n_promoted = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_reg(logic [tcpq_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
            if (idx == tcpq_pkg::REG_SUPPRESS_THRESHOLD)
                threshold = value;
            else if (idx == tcpq_pkg::REG_AGING_LIMIT)
                aging_limit = value;
        endfunction

        // Work out the result of one accepted request and queue it
        function void note_request(tcpq_pkg::req_t r);
            tcpq_pkg::rsp_t res;
            logic [63:0]    kept;
            logic [31:0]    age;
            res = '0;
            case (r.kind)
                tcpq_pkg::KIND_ENQUEUE:
                begin
                    n_enq++;
                    if (r.length == 0 || r.length > tcpq_pkg::MAX_BYTES)
                        res.status = tcpq_pkg::STAT_OVERSIZE;
                    else if (r.priority_req == tcpq_pkg::CLASS_INVALID)
                        res.status = tcpq_pkg::STAT_BAD_CLASS;
                    else
                    begin
                        // keep only the low length bytes
                        kept = (r.length >= 8) ? '1
                               : ((64'd1 << (8 * r.length)) - 64'd1);
                        kept = kept & r.payload;
                        case (r.priority_req)
                            tcpq_pkg::CLASS_URGENT:
                                if (urg_cnt >= UDEP)
                                    res.status = tcpq_pkg::STAT_FULL;
                                else
                                begin
                                    urg_pkt[urg_wr] = kept;
                                    urg_len[urg_wr] = r.length;
                                    urg_wr = (urg_wr + 1) % UDEP;
                                    urg_cnt++;
                                end
                            tcpq_pkg::CLASS_VOICE:
                                if (voi_cnt >= VDEP)
                                    res.status = tcpq_pkg::STAT_FULL;
                                else
                                begin
                                    voi_pkt[voi_wr] = kept;
                                    voi_len[voi_wr] = r.length;
                                    voi_wr = (voi_wr + 1) % VDEP;
                                    voi_cnt++;
                                end
                            default:
                                if (dat_cnt >= DDEP)
                                    res.status = tcpq_pkg::STAT_FULL;
                                else
                                begin
                                    dat_pkt[dat_wr]   = kept;
                                    dat_len[dat_wr]   = r.length;
                                    dat_stamp[dat_wr] = r.time_ms;
                                    dat_wr = (dat_wr + 1) % DDEP;
                                    dat_cnt++;
                                end
                        endcase
                    end
                end
                tcpq_pkg::KIND_DEQUEUE:
                begin
                    n_deq++;
                    // strict priority; skip a class whose head does not fit
                    if (urg_cnt > 0 && urg_len[urg_rd] <= r.out_capacity)
                    begin
                        res.out_payload = urg_pkt[urg_rd];
                        res.out_length  = urg_len[urg_rd];
                        res.out_class   = tcpq_pkg::CLASS_URGENT;
                        urg_rd = (urg_rd + 1) % UDEP;
                        urg_cnt--;
                    end
                    else if (voi_cnt > 0 && voi_len[voi_rd] <= r.out_capacity)
                    begin
                        res.out_payload = voi_pkt[voi_rd];
                        res.out_length  = voi_len[voi_rd];
                        res.out_class   = tcpq_pkg::CLASS_VOICE;
                        voi_rd = (voi_rd + 1) % VDEP;
                        voi_cnt--;
                    end
                    else if (!withheld && dat_cnt > 0 && dat_len[dat_rd] <= r.out_capacity)
                    begin
                        res.out_payload = dat_pkt[dat_rd];
                        res.out_length  = dat_len[dat_rd];
                        res.out_class   = tcpq_pkg::CLASS_DATA;
                        dat_rd = (dat_rd + 1) % DDEP;
                        dat_cnt--;
                    end
                    else
                        res.status = tcpq_pkg::STAT_EMPTY;
                    if (res.status == tcpq_pkg::STAT_OK)
                        n_served++;
                end
                tcpq_pkg::KIND_TICK:
                begin
                    n_tick++;
                    withheld = (r.noise_floor > threshold);
                    // promote an aged data head when voice has room
                    if (dat_cnt > 0)
                    begin
                        age = r.time_ms - dat_stamp[dat_rd];
                        if (age >= aging_limit && voi_cnt < VDEP)
                        begin
                            voi_pkt[voi_wr] = dat_pkt[dat_rd];
                            voi_len[voi_wr] = dat_len[dat_rd];
                            voi_wr = (voi_wr + 1) % VDEP;
                            voi_cnt++;
                            dat_rd = (dat_rd + 1) % DDEP;
                            dat_cnt--;
                            n_promoted++;
                        end
                    end
                end
                default:
                begin
                    n_flush++;
                    urg_rd = 0; urg_wr = 0; urg_cnt = 0;
                    voi_rd = 0; voi_wr = 0; voi_cnt = 0;
                    dat_rd = 0; dat_wr = 0; dat_cnt = 0;
                end
            endcase
            res.urgent_count  = tcpq_pkg::URG_CNT_W'(urg_cnt);
            res.voice_count   = tcpq_pkg::VOI_CNT_W'(voi_cnt);
            res.data_count    = tcpq_pkg::DAT_CNT_W'(dat_cnt);
            res.data_withheld = withheld;
            expected_results.push_back(res);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(tcpq_pkg::rsp_t got);
            tcpq_pkg::rsp_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with no request outstanding: expected none actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            compare("status", 64'(want.status), 64'(got.status));
            compare("out_payload", want.out_payload, got.out_payload);
            compare("out_length", 64'(want.out_length), 64'(got.out_length));
            compare("out_class", 64'(want.out_class), 64'(got.out_class));
            compare("urgent_count", 64'(want.urgent_count), 64'(got.urgent_count));
            compare("voice_count", 64'(want.voice_count), 64'(got.voice_count));
            compare("data_count", 64'(want.data_count), 64'(got.data_count));
            compare("data_withheld", 64'(want.data_withheld), 64'(got.data_withheld));
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_ready;
    tcpq_pkg::req_t                 req;
    logic                           rsp_valid;
    logic                           rsp_ready = 1'b0;
    tcpq_pkg::rsp_t                 rsp;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [tcpq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                    cfg_data;

    packet_queue_scoreboard sb;
    bit                     steady = 1'b0;
    int                     quiet_cycles = 0;
    int                     settings_used = 1;
    logic [31:0]            cur_thr = tcpq_pkg::SUPPRESS_THRESHOLD_RST;
    logic [31:0]            now_ms = '0;

    three_class_priority_packet_queue_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random, except in the steady stretch
    always @(posedge clk)
        rsp_ready <= steady || ($urandom_range(99) >= 11);

    // Sample handshakes, feed the scoreboard and watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if (req_valid && req_ready)
                sb.note_request(req);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[three_class_priority_packet_queue_core] ERROR");
                $finish;
            end
        end
    end

    function automatic tcpq_pkg::req_t make_item(logic [1:0] kind, logic [1:0] prio,
                                                 logic [63:0] pay, logic [LW-1:0] len,
                                                 logic [31:0] tstamp, logic [31:0] noise,
                                                 logic [LW-1:0] cap);
        tcpq_pkg::req_t r;
        r.kind         = kind;
        r.priority_req = prio;
        r.payload      = pay;
        r.length       = len;
        r.time_ms      = tstamp;
        r.noise_floor  = noise;
        r.out_capacity = cap;
        return r;
    endfunction

    // Build a mostly well-formed request with random content
    function automatic tcpq_pkg::req_t random_item();
        tcpq_pkg::req_t r;
        int             pick;
        r.kind         = 2'($urandom);
        r.priority_req = 2'($urandom);
        r.payload      = {$urandom, $urandom};
        r.length       = LW'($urandom);
        r.time_ms      = $urandom;
        r.noise_floor  = $urandom;
        r.out_capacity = LW'($urandom);
        now_ms = now_ms + $urandom_range(0, 300);
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            r.kind = tcpq_pkg::KIND_ENQUEUE;
            if ($urandom_range(99) < 88)
                r.length = LW'($urandom_range(1, tcpq_pkg::MAX_BYTES));
            if ($urandom_range(99) < 94)
                r.priority_req = 2'($urandom_range(0, 2));
            if ($urandom_range(99) < 95)
                r.time_ms = now_ms;
        end
        else if (pick < 80)
        begin
            r.kind = tcpq_pkg::KIND_DEQUEUE;
            if ($urandom_range(1))
                r.out_capacity = LW'($urandom_range(tcpq_pkg::MAX_BYTES, 15));
        end
        else if (pick < 98)
        begin
            r.kind = tcpq_pkg::KIND_TICK;
            if ($urandom_range(99) < 95)
                r.time_ms = now_ms;
            // hover round the threshold half the time
            if ($urandom_range(1))
                r.noise_floor = cur_thr + $urandom_range(0, 2) - 1;
        end
        else
            r.kind = tcpq_pkg::KIND_FLUSH;
        return r;
    endfunction

    // Present one request and hold it until taken
    task automatic send_item(input tcpq_pkg::req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every predicted result has arrived
    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back; only while the queue is idle
    task automatic set_config(input logic [31:0] thr, input logic [31:0] age_lim);
        cfg_index <= tcpq_pkg::REG_SUPPRESS_THRESHOLD;
        cfg_data  <= thr;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= tcpq_pkg::REG_AGING_LIMIT;
        cfg_data  <= age_lim;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_thr = thr;
        settings_used++;
    endtask

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty service, length and class checks, full ring
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd15));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_INVALID, '1, 4'd0, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd15, '1, '1,
                            4'd15));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_DATA, '1, 4'd9, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_INVALID, '1, 4'd8, '1, '1,
                            4'd15));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd8, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd1, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT,
                            64'h0123_4567_89AB_CDEF, 4'd4, '0, '0, 4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd7, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd2, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_VOICE, '1, 4'd3, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_DATA,
                            64'hA5A5_5A5A_F00F_0FF0, 4'd8, 32'hFFFF_FF00, '0, 4'd0));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_DATA, '1, 4'd1,
                            32'hFFFF_FFFF, '0, 4'd0));
        // head too long: nothing fits, then urgent skipped for voice
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '1, 4'd15, '1, '1,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd3));
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd15));
        // suppression and aging across the 32-bit wrap
        send_item(make_item(tcpq_pkg::KIND_TICK, tcpq_pkg::CLASS_URGENT, '0, 4'd0,
                            32'h0000_0700, '1, 4'd0));
        send_item(make_item(tcpq_pkg::KIND_TICK, tcpq_pkg::CLASS_URGENT, '0, 4'd0,
                            32'h0000_0700, tcpq_pkg::SUPPRESS_THRESHOLD_RST, 4'd0));
        send_item(make_item(tcpq_pkg::KIND_TICK, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0,
                            tcpq_pkg::SUPPRESS_THRESHOLD_RST + 32'd1, 4'd0));
        // flush keeps the withhold flag
        send_item(make_item(tcpq_pkg::KIND_FLUSH, tcpq_pkg::CLASS_URGENT, '1, 4'd8, '1, '1,
                            4'd15));
        send_item(make_item(tcpq_pkg::KIND_ENQUEUE, tcpq_pkg::CLASS_DATA, '1, 4'd5, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd15));
        send_item(make_item(tcpq_pkg::KIND_TICK, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd0));
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd5));
        send_item(make_item(tcpq_pkg::KIND_DEQUEUE, tcpq_pkg::CLASS_URGENT, '0, 4'd0, '0, '0,
                            4'd15));
        wait_for_results();

        // Random phases, each under a register setting; phases 0 and 5 both use the reset values
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1: set_config(32'd0, 32'd0);
                2: set_config('1, '1);
                3: set_config($urandom_range(0, 1000), $urandom_range(0, 4000));
                4: set_config($urandom, $urandom);
                5: set_config(tcpq_pkg::SUPPRESS_THRESHOLD_RST, tcpq_pkg::AGING_LIMIT_RST);
                default: ;
            endcase
            steady = (phase == 3);
            now_ms = $urandom;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item());
                if (phase == 1 && n == PHASE_ITEMS / 2)
                    wait_for_results();
                else if (!steady && $urandom_range(99) < 11)
                begin
                    req_valid <= 1'b0;
                    @(posedge clk);
                end
            end
            wait_for_results();
        end

        repeat (4) @(posedge clk);
        $display("Covered %0d requests: %0d enqueue, %0d dequeue (%0d served),",
                 sb.n_enq + sb.n_deq + sb.n_tick + sb.n_flush, sb.n_enq, sb.n_deq,
                 sb.n_served);
        $display("  %0d tick (%0d promoted), %0d flush; checked %0d results under %0d settings",
                 sb.n_tick, sb.n_promoted, sb.n_flush, sb.results_checked, settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[three_class_priority_packet_queue_core] OK");
        else
            $display("[three_class_priority_packet_queue_core] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/tcpq_pkg.sv
sv/three_class_priority_packet_queue_core.sv
tb/three_class_priority_packet_queue_core_tb.sv
